FILE: rtl/sfc_pkg.sv
`default_nettype none

package sfc_pkg;

    // Field widths fixed by the interface
    localparam int unsigned DATA_W  = 8;
    localparam int unsigned IDX_W   = 6;
    localparam int unsigned CFG_A_W = 2;

    // Default frame length, header/tail values and idle gap
    localparam int unsigned FRAME_LEN_DEF   = 22;
    localparam logic [DATA_W-1:0] HEADER_RST = 8'hAA;
    localparam logic [DATA_W-1:0] TAIL_RST   = 8'h0D;
    localparam logic [DATA_W-1:0] GAP_RST    = 8'd50;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_HEADER = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_TAIL   = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_GAP    = 2'd2;

    // Input item kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/serial_frame_checker.sv
// A byte accepted into the input register moves into the result register when it
// advances; the result register then holds it until it is taken.
// Throughput: one item per cycle unless the output side stalls; the output
// register frees in the same cycle it is taken, so input stall only rises
// while the output side stalls. Ticks produce no output beat.
// Reset: asynchronous, active low; clears frame state, countdown and valids,
// and loads header 0xAA, tail 0x0D and gap 50.
`default_nettype none

module serial_frame_checker
    import sfc_pkg::*;
#(
    parameter int unsigned FRAME_LEN = FRAME_LEN_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                req_type,
    input  wire logic [DATA_W-1:0]   rx_byte,

    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [DATA_W-1:0]        byte_value,
    output logic [IDX_W-1:0]         byte_index,
    output logic                     frame_end,
    output logic                     frame_good,
    output logic                     overrun,

    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CFG_A_W-1:0]  cfg_index,
    input  wire logic [DATA_W-1:0]   cfg_data
);

    localparam int unsigned CNT_W = $clog2(FRAME_LEN + 1);
    localparam logic [CNT_W-1:0] LEN_C  = CNT_W'(FRAME_LEN);
    localparam logic [CNT_W-1:0] CHK_POS = CNT_W'(FRAME_LEN - 2);
    localparam logic [CNT_W-1:0] END_POS = CNT_W'(FRAME_LEN - 1);

    // Configuration registers
    logic [DATA_W-1:0] header_reg;
    logic [DATA_W-1:0] tail_reg;
    logic [DATA_W-1:0] gap_reg;

    // Input stage
    logic              s1_valid_reg;
    logic              s1_type_reg;
    logic [DATA_W-1:0] s1_byte_reg;

    // Frame state
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic [DATA_W-1:0] sum_reg,  sum_next;
    logic [DATA_W-1:0] cd_reg,   cd_next;
    logic              hdr_reg,  hdr_next;
    logic [DATA_W-1:0] chk_reg,  chk_next;

    // Result stage
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_byte_reg, out_byte_next;
    logic [IDX_W-1:0]  out_idx_reg,  out_idx_next;
    logic              out_end_reg,  out_end_next;
    logic              out_good_reg, out_good_next;
    logic              out_ovr_reg,  out_ovr_next;

    logic              out_free;
    logic              s1_advance;
    logic              s1_is_byte;
    logic              new_frame;
    logic [CNT_W-1:0]  cnt_base;
    logic [DATA_W-1:0] sum_base;
    logic              hdr_base;
    logic [DATA_W-1:0] chk_base;

    // Handshake: output register frees when empty or taken this cycle
    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_is_byte = (s1_type_reg == REQ_BYTE);
    assign s1_advance = s1_valid_reg && (!s1_is_byte || out_free);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign cfg_ready  = 1'b1;

    // Work out the next frame state and the result for the held item
    always_comb
    begin
        new_frame = (cd_reg == '0);
        cnt_base  = new_frame ? '0 : cnt_reg;
        sum_base  = new_frame ? '0 : sum_reg;
        hdr_base  = new_frame ? 1'b0 : hdr_reg;
        chk_base  = new_frame ? '0 : chk_reg;

        cnt_next = cnt_reg;
        sum_next = sum_reg;
        cd_next  = cd_reg;
        hdr_next = hdr_reg;
        chk_next = chk_reg;

        out_byte_next = s1_byte_reg;
        out_idx_next  = '0;
        out_end_next  = 1'b0;
        out_good_next = 1'b0;
        out_ovr_next  = 1'b0;

        if (!s1_is_byte)
        begin
            // Tick: count the idle gap down, holding at zero
            if (cd_reg != '0)
                cd_next = cd_reg - 1'b1;
        end
        else
        begin
            cd_next  = gap_reg;
            sum_next = sum_base;
            hdr_next = hdr_base;
            chk_next = chk_base;
            if (cnt_base >= LEN_C)
            begin
                // Beyond the frame: drop the byte
                cnt_next     = LEN_C;
                out_ovr_next = 1'b1;
            end
            else
            begin
                if (cnt_base == '0)
                    hdr_next = (s1_byte_reg == header_reg);
                if (cnt_base < CHK_POS)
                    sum_next = sum_base + s1_byte_reg;
                else if (cnt_base == CHK_POS)
                    chk_next = s1_byte_reg;
                if (cnt_base == END_POS)
                begin
                    out_end_next  = 1'b1;
                    out_good_next = hdr_base && (s1_byte_reg == tail_reg)
                                    && (sum_base == chk_base);
                end
                cnt_next     = cnt_base + 1'b1;
                out_idx_next = IDX_W'(cnt_base);
            end
        end
    end

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RST;
            tail_reg   <= TAIL_RST;
            gap_reg    <= GAP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_HEADER)
                header_reg <= cfg_data;
            else if (cfg_index == REG_TAIL)
                tail_reg <= cfg_data;
            else if (cfg_index == REG_GAP)
                gap_reg <= cfg_data;
        end
    end

    // Input register: load on accept, drain on advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_valid && !in_stall)
            s1_valid_reg <= 1'b1;
        else if (s1_advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_type_reg <= req_type;
            s1_byte_reg <= rx_byte;
        end
    end

    // Frame state advances with each item leaving the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sum_reg <= '0;
            cd_reg  <= '0;
            hdr_reg <= 1'b0;
            chk_reg <= '0;
        end
        else if (s1_advance)
        begin
            cnt_reg <= cnt_next;
            sum_reg <= sum_next;
            cd_reg  <= cd_next;
            hdr_reg <= hdr_next;
            chk_reg <= chk_next;
        end
    end

    // Result register: one beat per byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance && s1_is_byte)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_is_byte)
        begin
            out_byte_reg <= out_byte_next;
            out_idx_reg  <= out_idx_next;
            out_end_reg  <= out_end_next;
            out_good_reg <= out_good_next;
            out_ovr_reg  <= out_ovr_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign byte_value = out_byte_reg;
    assign byte_index = out_idx_reg;
    assign frame_end  = out_end_reg;
    assign frame_good = out_good_reg;
    assign overrun    = out_ovr_reg;

    // Checks on the frame logic
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LEN_C)
        else $error("byte count beyond frame length");

    a_good_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_good_reg |-> out_end_reg && !out_ovr_reg)
        else $error("frame good reported away from frame end");

    a_end_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_end_reg |-> out_idx_reg == IDX_W'(FRAME_LEN - 1))
        else $error("frame end at wrong index");

    a_ovr_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_ovr_reg |-> out_idx_reg == '0 && !out_end_reg)
        else $error("overrun beat carries frame fields");

    a_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && !s1_is_byte && !out_valid_reg |=> !out_valid_reg)
        else $error("tick produced a result beat");

endmodule

`default_nettype wire
